### design/vtcc_pkg.sv
package vtcc_pkg;

	// run status codes as they appear on the result item
	typedef enum logic [2:0] {
		STAT_RUNNING = 3'd0,
		STAT_SUCCESS = 3'd1,
		STAT_TIMEOUT = 3'd2,
		STAT_ABORTED = 3'd3,
		STAT_ERROR   = 3'd4,
		STAT_INVALID = 3'd5
	} vtcc_status_t;

	// register index, byte address 4*index
	typedef enum logic [1:0] {
		REG_TARGET  = 2'd0,
		REG_THRESH  = 2'd1,
		REG_TIMEOUT = 2'd2,
		REG_TOL     = 2'd3
	} vtcc_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PROD,
		ST_MUL,
		ST_DONE
	} vtcc_state_t;

	typedef struct packed {
		logic [15:0] target_mv;
		logic [14:0] thresh_ma;
		logic [31:0] timeout_ms;
		logic [9:0]  tol_mv;
	} vtcc_cfg_t;

	typedef struct packed {
		logic clear;
		logic en;
		logic neg;
	} vtcc_acc_ctl_t;

	localparam logic [9:0] TOL_RESET = 10'd50;
	localparam int unsigned OUT_W = 168;

endpackage

### design/voltage_target_coulomb_counter.sv
// channel  | signals                          | item
// ---------+----------------------------------+-------------------------------------------
// s_axis   | tvalid tready tdata[71:0] tuser  | one sample (mode in tuser)
// m_axis   | tvalid tready tdata[167:0]       | one result per sample
// apb      | psel penable pwrite paddr pwdata | target, threshold, timeout, tolerance
//
// Start samples and loop samples that do not integrate go from idle to the finish state,
// then to the output register. Integrating loop samples pass through the 17-step serial
// voltage*current products followed by the 32-step serial multiply by the interval.
// Output register holds one result; the next sample is taken while it waits.
// arst_n clears config (tolerance to 50 mV), run state and both totals.
// A stalled m_axis holds the block in its finish state; nothing is dropped.
module voltage_target_coulomb_counter (
	input  logic         clk,
	input  logic         arst_n,
	// APB config
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [3:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready,
	// samples in
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// [15:0] voltage_mv, [31:16] current_ma, [63:32] time_ms, [64] cancel,
	// [65] read_error, [71:66] zero
	input  logic [71:0]  s_axis_tdata,
	// [0] mode
	input  logic [0:0]   s_axis_tuser,
	// results out
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// [2:0] status, [3] charging, [19:4] start_voltage, [35:20] final_voltage,
	// [99:36] charge_total, [163:100] energy_total, [167:164] zero
	output logic [167:0] m_axis_tdata
);
	import vtcc_pkg::*;

	function automatic logic [16:0] mag16(input logic [15:0] raw);
		mag16 = raw[15] ? 17'(17'h10000 - {1'b0, raw}) : {1'b0, raw};
	endfunction

	vtcc_cfg_t     cfg;
	vtcc_state_t   state_q, state_nxt;
	vtcc_status_t  status_q;
	vtcc_acc_ctl_t acc_ctl;

	logic        dir_q, primed_q;
	logic [15:0] prev_cur_q, prev_volt_q, start_volt_q, final_volt_q;
	logic [31:0] prev_time_q, dt_q;
	logic [16:0] csum_q;

	logic out_valid_q;
	logic [OUT_W-1:0] out_data_q;

	// sample fields
	logic        in_mode, in_cancel, in_rderr;
	logic [15:0] in_volt, in_cur;
	logic [31:0] in_time;
	assign in_mode   = s_axis_tuser[0];
	assign in_volt   = s_axis_tdata[15:0];
	assign in_cur    = s_axis_tdata[31:16];
	assign in_time   = s_axis_tdata[63:32];
	assign in_cancel = s_axis_tdata[64];
	assign in_rderr  = s_axis_tdata[65];

	logic        accept;
	logic [16:0] cmag, pmag;
	logic [15:0] vdiff;
	logic        near, low_cur, tmo_hit, arith_go;
	logic        out_free, out_load, mul_go;

	assign accept  = s_axis_tvalid && s_axis_tready;
	assign cmag    = mag16(in_cur);
	assign pmag    = mag16(prev_cur_q);
	assign vdiff   = (in_volt > cfg.target_mv) ? in_volt - cfg.target_mv
	                                           : cfg.target_mv - in_volt;
	assign near    = vdiff < {6'd0, cfg.tol_mv};
	assign low_cur = cmag < {2'd0, cfg.thresh_ma};
	assign tmo_hit = in_time > cfg.timeout_ms;

	// loop sample that reaches the integration step
	assign arith_go = accept && in_mode && (status_q == STAT_RUNNING) && !tmo_hit
		&& !in_rderr && !in_cancel && !(near && low_cur) && primed_q;

	vtcc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// power terms: V_prev*|I_prev| and V*|I|
	logic        p1_busy, p1_done, p2_busy, p2_done;
	logic [32:0] p1_prod, p2_prod;

	vtcc_smul #(.AW(16), .BW(17)) u_mul_p1 (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (arith_go),
		.a      (prev_volt_q),
		.b      (pmag),
		.busy   (p1_busy),
		.done   (p1_done),
		.prod   (p1_prod)
	);

	vtcc_smul #(.AW(16), .BW(17)) u_mul_p2 (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (arith_go),
		.a      (in_volt),
		.b      (cmag),
		.busy   (p2_busy),
		.done   (p2_done),
		.prod   (p2_prod)
	);

	// times the interval: energy and charge in parallel
	logic        e_busy, e_done, q_busy, q_done;
	logic [33:0] psum;
	logic [65:0] e_prod;
	logic [48:0] q_prod;
	logic [63:0] e_mag, q_mag;

	assign psum = {1'b0, p1_prod} + {1'b0, p2_prod};

	vtcc_smul #(.AW(34), .BW(32)) u_mul_e (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_go),
		.a      (psum),
		.b      (dt_q),
		.busy   (e_busy),
		.done   (e_done),
		.prod   (e_prod)
	);

	vtcc_smul #(.AW(17), .BW(32)) u_mul_q (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_go),
		.a      (csum_q),
		.b      (dt_q),
		.busy   (q_busy),
		.done   (q_done),
		.prod   (q_prod)
	);

	// energy product past 64 bits saturates
	assign e_mag = (e_prod[65:64] != 2'd0) ? {64{1'b1}} : e_prod[63:0];
	assign q_mag = {15'd0, q_prod};

	logic [63:0] charge_acc, energy_acc;

	vtcc_satacc u_acc_q (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (acc_ctl),
		.mag    (q_mag),
		.acc    (charge_acc)
	);

	vtcc_satacc u_acc_e (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (acc_ctl),
		.mag    (e_mag),
		.acc    (energy_acc)
	);

	// sequencer
	assign out_free = !out_valid_q || m_axis_tready;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: if (accept) begin
				state_nxt = arith_go ? ST_PROD : ST_DONE;
			end
			ST_PROD: if (p1_done && p2_done) begin
				state_nxt = ST_MUL;
			end
			ST_MUL: if (e_done) begin
				state_nxt = ST_DONE;
			end
			ST_DONE: if (out_free) begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		s_axis_tready = (state_q == ST_IDLE);
		mul_go        = (state_q == ST_PROD) && p1_done && p2_done;
		acc_ctl.en    = (state_q == ST_MUL) && e_done;
		acc_ctl.clear = accept && !in_mode;
		acc_ctl.neg   = !dir_q;
		out_load      = (state_q == ST_DONE) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// run state, updated at accept; totals follow after the multiply
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q     <= STAT_RUNNING;
			dir_q        <= 1'b0;
			primed_q     <= 1'b0;
			prev_cur_q   <= '0;
			prev_volt_q  <= '0;
			prev_time_q  <= '0;
			start_volt_q <= '0;
			final_volt_q <= '0;
		end else if (accept) begin
			if (!in_mode) begin
				dir_q       <= 1'b0;
				primed_q    <= 1'b0;
				prev_cur_q  <= '0;
				prev_volt_q <= '0;
				prev_time_q <= '0;
				if (cfg.target_mv == 16'd0 || cfg.timeout_ms == 32'd0) begin
					status_q     <= STAT_INVALID;
					start_volt_q <= '0;
					final_volt_q <= '0;
				end else begin
					start_volt_q <= in_volt;
					dir_q        <= cfg.target_mv > in_volt;
					final_volt_q <= near ? in_volt : 16'd0;
					status_q     <= near ? STAT_SUCCESS : STAT_RUNNING;
				end
			end else if (status_q == STAT_RUNNING) begin
				priority if (tmo_hit) begin
					status_q <= STAT_TIMEOUT;
				end else if (in_rderr) begin
					status_q <= STAT_ERROR;
				end else if (in_cancel) begin
					status_q <= STAT_ABORTED;
				end else if (near && low_cur) begin
					final_volt_q <= in_volt;
					status_q     <= STAT_SUCCESS;
				end else begin
					final_volt_q <= in_volt;
					prev_cur_q   <= in_cur;
					prev_volt_q  <= in_volt;
					prev_time_q  <= in_time;
					primed_q     <= 1'b1;
				end
			end
		end
	end

	// interval (backwards time counts as zero) and current sum for the charge term
	always_ff @(posedge clk) begin
		if (arith_go) begin
			dt_q   <= (in_time >= prev_time_q) ? in_time - prev_time_q : 32'd0;
			csum_q <= pmag + cmag;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= {4'd0, energy_acc, charge_acc, final_volt_q, start_volt_q,
			               dir_q, status_q};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

`ifndef NO_ASSERTIONS
	a_mul_running: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PROD || state_q == ST_MUL) |-> status_q == STAT_RUNNING)
		else $error("multiply in progress on a finished run");

	a_start_short: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !in_mode) |=> state_q == ST_DONE)
		else $error("start sample entered the multiply path");

	a_eq_align: assert property (@(posedge clk) disable iff (!arst_n)
		e_done |-> (q_done && !q_busy))
		else $error("energy and charge multipliers out of step");

	a_prod_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL) |-> (!p1_busy && !p2_busy && (e_busy || e_done)))
		else $error("power products still running during interval multiply");
`endif

endmodule

### design/vtcc_regs.sv
module vtcc_regs (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [3:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	output vtcc_pkg::vtcc_cfg_t cfg
);
	import vtcc_pkg::*;

	vtcc_cfg_t cfg_q;
	vtcc_reg_t idx;
	logic      wr;

	assign pready = 1'b1;
	assign idx    = vtcc_reg_t'(paddr[3:2]);
	assign wr     = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target_mv  <= '0;
			cfg_q.thresh_ma  <= '0;
			cfg_q.timeout_ms <= '0;
			cfg_q.tol_mv     <= TOL_RESET;
		end else if (wr) begin
			unique case (idx)
				REG_TARGET:  cfg_q.target_mv  <= pwdata[15:0];
				REG_THRESH:  cfg_q.thresh_ma  <= pwdata[14:0];
				REG_TIMEOUT: cfg_q.timeout_ms <= pwdata;
				REG_TOL:     cfg_q.tol_mv     <= pwdata[9:0];
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_TARGET:  prdata = {16'd0, cfg_q.target_mv};
			REG_THRESH:  prdata = {17'd0, cfg_q.thresh_ma};
			REG_TIMEOUT: prdata = cfg_q.timeout_ms;
			REG_TOL:     prdata = {22'd0, cfg_q.tol_mv};
		endcase
	end

endmodule

### design/vtcc_smul.sv
// shift-add multiplier, one multiplier bit per cycle, LSB first
module vtcc_smul #(
	parameter int unsigned AW = 16,
	parameter int unsigned BW = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [AW-1:0]      a,
	input  logic [BW-1:0]      b,
	output logic               busy,
	output logic               done,
	output logic [AW+BW-1:0]   prod
);
	localparam int unsigned CW = $clog2(BW);

	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [AW-1:0]    a_q;
	logic [AW+BW-1:0] prod_q;
	logic [AW:0]      sum;

	// partial sum of the upper half plus the multiplicand when the bit is set
	assign sum = {1'b0, prod_q[AW+BW-1:BW]} + (prod_q[0] ? {1'b0, a_q} : {(AW+1){1'b0}});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= '0;
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CW'(BW - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q    <= a;
			prod_q <= {{AW{1'b0}}, b};
		end else if (busy_q) begin
			prod_q <= {sum, prod_q[BW-1:1]};
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign prod = prod_q;

endmodule

### design/vtcc_satacc.sv
// signed 64-bit accumulator, saturating add or subtract of a magnitude
module vtcc_satacc (
	input  logic                    clk,
	input  logic                    arst_n,
	input  vtcc_pkg::vtcc_acc_ctl_t ctl,
	input  logic [63:0]             mag,
	output logic [63:0]             acc
);
	import vtcc_pkg::*;

	localparam logic [63:0] SIGN = {1'b1, 63'd0};

	logic [63:0] acc_q;
	logic [63:0] biased;
	logic [64:0] sum;
	logic [64:0] diff;
	logic [63:0] nxt;

	// offset-binary form turns signed limits into 0 and all ones
	assign biased = acc_q ^ SIGN;
	assign sum    = {1'b0, biased} + {1'b0, mag};
	assign diff   = {1'b0, biased} - {1'b0, mag};

	always_comb begin
		if (ctl.neg) begin
			nxt = diff[64] ? 64'd0 : diff[63:0];
		end else begin
			nxt = sum[64] ? {64{1'b1}} : sum[63:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctl.clear) begin
			acc_q <= '0;
		end else if (ctl.en) begin
			acc_q <= nxt ^ SIGN;
		end
	end

	assign acc = acc_q;

endmodule

### dv/voltage_target_coulomb_counter_tb.sv
module voltage_target_coulomb_counter_tb;
	import vtcc_pkg::*;

	// mode bit carried in tuser
	localparam logic MODE_START = 1'b0;
	localparam logic MODE_LOOP  = 1'b1;

	typedef enum logic {
		ROW_SAMPLE,
		ROW_WRITE
	} row_kind_t;

	// one expected result item
	typedef struct packed {
		vtcc_status_t status;
		logic         charging;
		logic [15:0]  start_mv;
		logic [15:0]  final_mv;
		logic [63:0]  charge;
		logic [63:0]  energy;
	} coulomb_result_t;

	// one line of the directed plan: either a sample or a register write
	typedef struct packed {
		row_kind_t    kind;
		logic         mode;
		logic [15:0]  volt_mv;
		logic [15:0]  cur_ma;
		logic [31:0]  t_ms;
		logic         cancel;
		logic         rd_err;
		logic         typed;
		vtcc_status_t want_status;
		vtcc_reg_t    reg_idx;
		logic [31:0]  reg_val;
	} plan_row_t;

	logic         clk;
	logic         arst_n;
	logic         psel;
	logic         penable;
	logic         pwrite;
	logic [3:0]   paddr;
	logic [31:0]  pwdata;
	logic [31:0]  prdata;
	logic         pready;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	// [15:0] voltage_mv, [31:16] current_ma, [63:32] time_ms, [64] cancel, [65] read_error
	logic [71:0]  s_axis_tdata;
	// [0] mode
	logic [0:0]   s_axis_tuser;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	// [2:0] status, [3] charging, [19:4] start_voltage, [35:20] final_voltage,
	// [99:36] charge_total, [163:100] energy_total
	logic [167:0] m_axis_tdata;

	voltage_target_coulomb_counter u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	// idle percentages, changed between stimulus groups
	int send_idle_pct = 18;
	int rcv_idle_pct  = 72;
	int mismatch_cnt  = 0;

	coulomb_result_t awaited_results[$];
	plan_row_t       plan[$];

	// predictor copy of the config registers
	logic [15:0] cfg_target  = '0;
	logic [14:0] cfg_thresh  = '0;
	logic [31:0] cfg_timeout = '0;
	logic [9:0]  cfg_tol     = TOL_RESET;

	// predictor copy of the run state
	logic         dir_chg    = 1'b0;
	logic         primed     = 1'b0;
	logic [15:0]  prev_cur   = '0;
	logic [15:0]  prev_volt  = '0;
	logic [31:0]  prev_t     = '0;
	logic [63:0]  charge_acc = '0;
	logic [63:0]  energy_acc = '0;
	logic [15:0]  start_v    = '0;
	logic [15:0]  final_v    = '0;
	vtcc_status_t run_stat   = STAT_RUNNING;

	// ------------------------------------------------------------------
	// predictor helpers
	// ------------------------------------------------------------------

	// |raw| of a 16-bit two's complement current, 0..32768
	function automatic logic [16:0] amp_mag(logic [15:0] raw);
		return raw[15] ? (17'h10000 - {1'b0, raw}) : {1'b0, raw};
	endfunction

	function automatic logic [15:0] mv_gap(logic [15:0] a, logic [15:0] b);
		return (a > b) ? a - b : b - a;
	endfunction

	// signed 64-bit accumulate of a magnitude, clamped at both limits
	function automatic logic [63:0] clamp_add(logic [63:0] acc, logic [63:0] mag, logic neg);
		logic [63:0] biased;
		logic [64:0] sum;
		biased = acc ^ 64'h8000_0000_0000_0000;
		if (!neg) begin
			sum = {1'b0, biased} + {1'b0, mag};
			biased = sum[64] ? '1 : sum[63:0];
		end else begin
			biased = (mag > biased) ? '0 : biased - mag;
		end
		return biased ^ 64'h8000_0000_0000_0000;
	endfunction

	// advances the predicted run state by one accepted sample, returns the result item
	function automatic coulomb_result_t integrate_sample(logic mode, logic [15:0] volt,
			logic [15:0] cur, logic [31:0] t, logic cancel, logic rd_err);
		coulomb_result_t res;
		logic [16:0] cmag;
		logic [16:0] pmag;
		logic [31:0] dt;
		logic [63:0] q;
		logic [63:0] p;
		logic [65:0] e_full;
		logic [63:0] e;
		cmag = amp_mag(cur);
		if (mode == MODE_START) begin
			dir_chg = 1'b0;
			primed = 1'b0;
			prev_cur = '0;
			prev_volt = '0;
			prev_t = '0;
			charge_acc = '0;
			energy_acc = '0;
			start_v = '0;
			final_v = '0;
			run_stat = STAT_RUNNING;
			if (cfg_target == '0 || cfg_timeout == '0) begin
				run_stat = STAT_INVALID;
			end else begin
				start_v = volt;
				dir_chg = cfg_target > volt;
				if (mv_gap(cfg_target, volt) < {6'd0, cfg_tol}) begin
					final_v = volt;
					run_stat = STAT_SUCCESS;
				end
			end
		end else if (run_stat == STAT_RUNNING) begin
			// check order: timeout, read error, cancel, then target reached
			if (t > cfg_timeout) begin
				run_stat = STAT_TIMEOUT;
			end else if (rd_err) begin
				run_stat = STAT_ERROR;
			end else if (cancel) begin
				run_stat = STAT_ABORTED;
			end else begin
				final_v = volt;
				if (mv_gap(volt, cfg_target) < {6'd0, cfg_tol} && cmag < {2'd0, cfg_thresh}) begin
					run_stat = STAT_SUCCESS;
				end else begin
					if (primed) begin
						pmag = amp_mag(prev_cur);
						dt = (t >= prev_t) ? t - prev_t : '0;
						q = (64'(pmag) + 64'(cmag)) * 64'(dt);
						p = 64'(prev_volt) * 64'(pmag) + 64'(volt) * 64'(cmag);
						e_full = 66'(p) * 66'(dt);
						e = (e_full[65:64] != 2'b00) ? '1 : e_full[63:0];
						charge_acc = clamp_add(charge_acc, q, !dir_chg);
						energy_acc = clamp_add(energy_acc, e, !dir_chg);
					end
					prev_cur = cur;
					prev_volt = volt;
					prev_t = t;
					primed = 1'b1;
				end
			end
		end
		res.status = run_stat;
		res.charging = dir_chg;
		res.start_mv = start_v;
		res.final_mv = final_v;
		res.charge = charge_acc;
		res.energy = energy_acc;
		return res;
	endfunction

	// ------------------------------------------------------------------
	// bus tasks
	// ------------------------------------------------------------------

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		mismatch_cnt++;
		if (mismatch_cnt <= 40)
			$display("[%0t] mismatch %s: got %0h, want %0h", $time, what, got, want);
	endtask

	task automatic check_result(input logic [167:0] d);
		coulomb_result_t want;
		if (awaited_results.size() == 0) begin
			report_mismatch("result with nothing pending", d[63:0], '0);
			return;
		end
		want = awaited_results.pop_front();
		if (d[2:0] != want.status)
			report_mismatch("status", 64'(d[2:0]), 64'(want.status));
		if (d[3] != want.charging)
			report_mismatch("charging", 64'(d[3]), 64'(want.charging));
		if (d[19:4] != want.start_mv)
			report_mismatch("start_voltage", 64'(d[19:4]), 64'(want.start_mv));
		if (d[35:20] != want.final_mv)
			report_mismatch("final_voltage", 64'(d[35:20]), 64'(want.final_mv));
		if (d[99:36] != want.charge)
			report_mismatch("charge_total", d[99:36], want.charge);
		if (d[163:100] != want.energy)
			report_mismatch("energy_total", d[163:100], want.energy);
	endtask

	// Drives one sample and waits for the handshake. tvalid is left high on
	// return; the next call or drain_block decides its value in the same step.
	task automatic send_sample(input logic mode, input logic [15:0] volt, input logic [15:0] cur,
			input logic [31:0] t, input logic cancel, input logic rd_err,
			input logic typed, input vtcc_status_t typed_status);
		coulomb_result_t want;
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= mode;
		s_axis_tdata <= {6'd0, rd_err, cancel, t, cur, volt};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		want = integrate_sample(mode, volt, cur, t, cancel, rd_err);
		if (typed)
			want.status = typed_status;
		awaited_results.push_back(want);
	endtask

	// every item yields one result, so an empty queue means the block is idle
	task automatic drain_block();
		s_axis_tvalid <= 1'b0;
		while (awaited_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input vtcc_reg_t idx, input logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_TARGET:  cfg_target = value[15:0];
			REG_THRESH:  cfg_thresh = value[14:0];
			REG_TIMEOUT: cfg_timeout = value;
			REG_TOL:     cfg_tol = value[9:0];
			default:     ;
		endcase
	endtask

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------

	function automatic plan_row_t sample_row(logic mode, logic [15:0] volt, logic [15:0] cur,
			logic [31:0] t, logic cancel, logic rd_err, logic typed, vtcc_status_t want);
		plan_row_t r;
		r = '0;
		r.kind = ROW_SAMPLE;
		r.mode = mode;
		r.volt_mv = volt;
		r.cur_ma = cur;
		r.t_ms = t;
		r.cancel = cancel;
		r.rd_err = rd_err;
		r.typed = typed;
		r.want_status = want;
		return r;
	endfunction

	function automatic plan_row_t write_row(vtcc_reg_t idx, logic [31:0] value);
		plan_row_t r;
		r = '0;
		r.kind = ROW_WRITE;
		r.reg_idx = idx;
		r.reg_val = value;
		return r;
	endfunction

	function automatic int clip_mv(int v);
		if (v < 0)
			return 0;
		if (v > 65535)
			return 65535;
		return v;
	endfunction

	// register value with junk in the unused upper bits now and then
	function automatic logic [31:0] with_junk(logic [31:0] value, int width);
		if (width < 32 && $urandom_range(3) == 0)
			return value | ($urandom << width);
		return value;
	endfunction

	task automatic load_random_config();
		logic [31:0] tgt;
		logic [31:0] thr;
		logic [31:0] tmo;
		logic [31:0] tol;
		case ($urandom_range(3))
			0:       tgt = 65535;
			1:       tgt = $urandom_range(1, 300);
			default: tgt = $urandom_range(2500, 4500);
		endcase
		if ($urandom_range(11) == 0)
			tgt = 0;
		case ($urandom_range(3))
			0:       thr = 0;
			1:       thr = 32767;
			2:       thr = $urandom_range(0, 32767);
			default: thr = $urandom_range(0, 2000);
		endcase
		case ($urandom_range(3))
			0:       tmo = 32'hFFFF_FFFF;
			1:       tmo = $urandom_range(1, 2000);
			2:       tmo = $urandom;
			default: tmo = $urandom_range(1000, 30000);
		endcase
		if ($urandom_range(11) == 0)
			tmo = 0;
		case ($urandom_range(3))
			0:       tol = 0;
			1:       tol = 1023;
			2:       tol = $urandom_range(0, 1023);
			default: tol = $urandom_range(0, 200);
		endcase
		write_reg(REG_TARGET, with_junk(tgt, 16));
		write_reg(REG_THRESH, with_junk(thr, 15));
		write_reg(REG_TIMEOUT, tmo);
		write_reg(REG_TOL, with_junk(tol, 10));
	endtask

	// Mostly well-formed runs: a start, then loop samples walking toward the
	// target with rising time. About one item in ten is pure noise. Samples
	// that a finished run ignores are not counted.
	task automatic random_phase(input int n_items);
		int          done_items;
		int          v_now;
		int          seq_len;
		int          k;
		int          mag;
		logic [31:0] t_now;
		logic [15:0] cur;
		logic        mode;
		logic        live;
		done_items = 0;
		while (done_items < n_items) begin
			if ($urandom_range(9) == 0) begin
				mode = 1'($urandom_range(1));
				live = (mode == MODE_START) || (run_stat == STAT_RUNNING);
				send_sample(mode, 16'($urandom), 16'($urandom), $urandom,
					1'($urandom_range(1)), 1'($urandom_range(1)), 1'b0, STAT_RUNNING);
				if (live)
					done_items++;
			end else begin
				case ($urandom_range(7))
					0:       v_now = 0;
					1:       v_now = 65535;
					default: v_now = clip_mv(int'(cfg_target) + int'($urandom_range(0, 6000)) - 3000);
				endcase
				send_sample(MODE_START, 16'(v_now), 16'($urandom), $urandom,
					1'($urandom_range(1)), 1'($urandom_range(1)), 1'b0, STAT_RUNNING);
				done_items++;
				seq_len = $urandom_range(1, 14);
				t_now = $urandom_range(0, 300);
				for (k = 0; k < seq_len; k++) begin
					// a finished run mostly ends the sequence; sometimes poke it once more
					if (run_stat != STAT_RUNNING && $urandom_range(3) != 0)
						break;
					live = (run_stat == STAT_RUNNING);
					if (v_now < int'(cfg_target))
						v_now = v_now + int'($urandom_range(0, 400));
					else
						v_now = v_now - int'($urandom_range(0, 400));
					if ($urandom_range(3) == 0)
						v_now = v_now + int'($urandom_range(0, 200)) - 100;
					v_now = clip_mv(v_now);
					if ($urandom_range(2) == 0)
						mag = $urandom_range(0, int'(cfg_thresh) + 5);
					else
						mag = $urandom_range(0, 32768);
					cur = $urandom_range(1) ? 16'(-mag) : 16'(mag);
					send_sample(MODE_LOOP, 16'(v_now), cur, t_now, $urandom_range(49) == 0,
						$urandom_range(49) == 0, 1'b0, STAT_RUNNING);
					if (live)
						done_items++;
					case ($urandom_range(29))
						0:       t_now = $urandom;
						1:       t_now = t_now - $urandom_range(0, 500);
						2:       ;
						default: t_now = t_now + $urandom_range(1, 2000);
					endcase
				end
			end
		end
	endtask

	// ------------------------------------------------------------------
	// clock, limit, receiver
	// ------------------------------------------------------------------

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// hard stop: far beyond the slowest legal run
	initial begin
		#12_000_000;
		$display("Some tests failed");
		$finish;
	end

	// Result side: compare at each accepted item, then pick the next tready.
	// Values read right after the edge are the ones the block saw at it.
	initial begin
		m_axis_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready)
				check_result(m_axis_tdata);
			m_axis_tready <= ($urandom_range(99) >= rcv_idle_pct);
		end
	end

	// ------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------

	initial begin
		int grp;
		int ph;
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		s_axis_tuser <= MODE_START;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// From reset: target and timeout are zero, tolerance 50, status running.
		// Loop samples before any start are processed with those registers.
		plan.push_back(sample_row(MODE_LOOP, 16'd10, 16'd100, 32'd0, 1'b0, 1'b0, 1'b1, STAT_RUNNING));
		plan.push_back(sample_row(MODE_LOOP, 16'd20, -16'sd100, 32'd5, 1'b0, 1'b0, 1'b1, STAT_TIMEOUT));
		// start with zero target: invalid setup, everything cleared
		plan.push_back(sample_row(MODE_START, 16'd3000, 16'd0, 32'd0, 1'b0, 1'b0, 1'b1, STAT_INVALID));
		plan.push_back(write_row(REG_TARGET, 32'd4200));
		plan.push_back(write_row(REG_THRESH, 32'd100));
		plan.push_back(write_row(REG_TIMEOUT, 32'd1000));
		// already inside tolerance: done at once, later loops only repeat it
		plan.push_back(sample_row(MODE_START, 16'd4190, 16'd0, 32'd0, 1'b0, 1'b0, 1'b1, STAT_SUCCESS));
		plan.push_back(sample_row(MODE_LOOP, 16'd3000, 16'd500, 32'd10, 1'b0, 1'b0, 1'b1, STAT_SUCCESS));
		// charging run: prime, full-scale currents, time running backwards, then a timeout
		plan.push_back(sample_row(MODE_START, 16'd3000, 16'd0, 32'd0, 1'b0, 1'b0, 1'b1, STAT_RUNNING));
		plan.push_back(sample_row(MODE_LOOP, 16'd3100, 16'h7FFF, 32'd0, 1'b0, 1'b0, 1'b0, STAT_RUNNING));
		plan.push_back(sample_row(MODE_LOOP, 16'd3200, 16'h8000, 32'd100, 1'b0, 1'b0, 1'b0, STAT_RUNNING));
		plan.push_back(sample_row(MODE_LOOP, 16'hFFFF, 16'hFFFF, 32'd50, 1'b0, 1'b0, 1'b0, STAT_RUNNING));
		plan.push_back(sample_row(MODE_LOOP, 16'd3300, 16'd500, 32'd1001, 1'b0, 1'b0, 1'b1, STAT_TIMEOUT));
		// read error, cancel, and the order among the three exits
		plan.push_back(sample_row(MODE_START, 16'd3000, 16'd0, 32'd0, 1'b0, 1'b0, 1'b0, STAT_RUNNING));
		plan.push_back(sample_row(MODE_LOOP, 16'd3000, 16'd500, 32'd10, 1'b0, 1'b1, 1'b1, STAT_ERROR));
		plan.push_back(sample_row(MODE_START, 16'd3000, 16'd0, 32'd0, 1'b0, 1'b0, 1'b0, STAT_RUNNING));
		plan.push_back(sample_row(MODE_LOOP, 16'd3000, 16'd500, 32'd10, 1'b1, 1'b0, 1'b1, STAT_ABORTED));
		plan.push_back(sample_row(MODE_START, 16'd3000, 16'd0, 32'd0, 1'b0, 1'b0, 1'b0, STAT_RUNNING));
		plan.push_back(sample_row(MODE_LOOP, 16'd3000, 16'd500, 32'd10, 1'b1, 1'b1, 1'b1, STAT_ERROR));
		plan.push_back(sample_row(MODE_START, 16'd3000, 16'd0, 32'd0, 1'b0, 1'b0, 1'b0, STAT_RUNNING));
		plan.push_back(sample_row(MODE_LOOP, 16'd3000, 16'd500, 32'd2000, 1'b1, 1'b1, 1'b1, STAT_TIMEOUT));
		// target reached with low current on the first loop sample
		plan.push_back(sample_row(MODE_START, 16'd3000, 16'd0, 32'd0, 1'b0, 1'b0, 1'b0, STAT_RUNNING));
		plan.push_back(sample_row(MODE_LOOP, 16'd4190, 16'd50, 32'd10, 1'b0, 1'b0, 1'b1, STAT_SUCCESS));
		// discharging run: negative totals, then success just inside both limits
		plan.push_back(sample_row(MODE_START, 16'd60000, 16'd0, 32'd0, 1'b0, 1'b0, 1'b0, STAT_RUNNING));
		plan.push_back(sample_row(MODE_LOOP, 16'd59000, -16'sd2000, 32'd0, 1'b0, 1'b0, 1'b0, STAT_RUNNING));
		plan.push_back(sample_row(MODE_LOOP, 16'd58000, 16'd3000, 32'd400, 1'b0, 1'b0, 1'b0, STAT_RUNNING));
		plan.push_back(sample_row(MODE_LOOP, 16'd4199, -16'sd99, 32'd500, 1'b0, 1'b0, 1'b1, STAT_SUCCESS));
		// extremes: max target and timeout, zero tolerance, energy clamps high
		plan.push_back(write_row(REG_TARGET, 32'd65535));
		plan.push_back(write_row(REG_THRESH, 32'd0));
		plan.push_back(write_row(REG_TIMEOUT, 32'hFFFF_FFFF));
		plan.push_back(write_row(REG_TOL, 32'd0));
		plan.push_back(sample_row(MODE_START, 16'd0, 16'd0, 32'd0, 1'b0, 1'b0, 1'b1, STAT_RUNNING));
		plan.push_back(sample_row(MODE_LOOP, 16'hFFFF, 16'h8000, 32'd0, 1'b0, 1'b0, 1'b0, STAT_RUNNING));
		plan.push_back(sample_row(MODE_LOOP, 16'hFFFF, 16'h8000, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0,
			STAT_RUNNING));
		// widest tolerance and threshold, target 1: edges of both comparisons
		plan.push_back(write_row(REG_TOL, 32'd1023));
		plan.push_back(write_row(REG_THRESH, 32'd32767));
		plan.push_back(write_row(REG_TARGET, 32'd1));
		plan.push_back(sample_row(MODE_START, 16'd1024, 16'd0, 32'd0, 1'b0, 1'b0, 1'b1, STAT_RUNNING));
		plan.push_back(sample_row(MODE_LOOP, 16'd1023, 16'h8001, 32'd7, 1'b0, 1'b0, 1'b0, STAT_RUNNING));
		plan.push_back(sample_row(MODE_LOOP, 16'd1000, 16'h8002, 32'd9, 1'b0, 1'b0, 1'b1, STAT_SUCCESS));

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_WRITE) begin
				drain_block();
				write_reg(plan[i].reg_idx, plan[i].reg_val);
			end else begin
				send_sample(plan[i].mode, plan[i].volt_mv, plan[i].cur_ma, plan[i].t_ms,
					plan[i].cancel, plan[i].rd_err, plan[i].typed, plan[i].want_status);
			end
		end

		// random part: three idling regimes, five register settings each
		for (grp = 0; grp < 3; grp++) begin
			case (grp)
				0: begin
					send_idle_pct = 18;
					rcv_idle_pct = 72;
				end
				1: begin
					send_idle_pct = 72;
					rcv_idle_pct = 18;
				end
				default: begin
					send_idle_pct = 0;
					rcv_idle_pct = 0;
				end
			endcase
			for (ph = 0; ph < 5; ph++) begin
				drain_block();
				load_random_config();
				random_phase(110);
			end
		end

		drain_block();
		// room for any stray result after the last one
		repeat (64) @(posedge clk);
		if (awaited_results.size() != 0)
			report_mismatch("results never delivered", 64'(awaited_results.size()), '0);
		if (mismatch_cnt == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

### voltage_target_coulomb_counter.f
design/vtcc_pkg.sv
design/vtcc_regs.sv
design/vtcc_smul.sv
design/vtcc_satacc.sv
design/voltage_target_coulomb_counter.sv
dv/voltage_target_coulomb_counter_tb.sv
